FILE: rtl/assert_macros.svh
// Assertion macros used by the checker module of the converter.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_PROP(lbl, !(expr), msg)

`endif

FILE: rtl/fhc_pkg.sv
// Shared types and constants of the single/half float converter.
// No dependencies.
package fhc_pkg;

  typedef enum logic [0:0] {
    CMD_NARROW = 1'b0,
    CMD_WIDEN  = 1'b1
  } cmd_e;

  typedef logic [31:0] single_t;
  typedef logic [15:0] half_t;

  localparam logic [7:0]  REBIAS      = 8'd112;
  localparam logic [7:0]  DENORM_BASE = 8'd113;
  localparam logic [7:0]  SINGLE_EXP_MAX = 8'hFF;
  localparam logic [4:0]  HALF_EXP_MAX   = 5'h1F;
  localparam logic [7:0]  HALF_EXP_OVF   = 8'd31;
  localparam logic [6:0]  DENORM_SH_MAX  = 7'd24;
  localparam logic [23:0] ROUND_INC      = 24'h001000;

endpackage

FILE: rtl/fhc_narrow.sv
// Combinational narrowing of a single-precision pattern to half precision.
// Depends on fhc_pkg.
module fhc_narrow (
  input  fhc_pkg::single_t single_i,
  output fhc_pkg::half_t   half_o
);

  logic        sign;
  logic [7:0]  exp8;
  logic [22:0] man;
  logic [7:0]  dn_shift_full;
  logic [6:0]  dn_shift;
  logic [23:0] dn_shifted;
  logic [23:0] dn_round;
  logic [23:0] nm_sum;
  logic [7:0]  nm_exp;
  logic [9:0]  nan_man;

  assign sign          = single_i[31];
  assign exp8          = single_i[30:23];
  assign man           = single_i[22:0];
  assign dn_shift_full = fhc_pkg::DENORM_BASE - exp8;
  assign dn_shift      = dn_shift_full[6:0];
  assign dn_shifted    = {1'b1, man} >> dn_shift[4:0];
  assign dn_round      = dn_shifted + fhc_pkg::ROUND_INC;
  assign nm_sum        = {1'b0, man} + fhc_pkg::ROUND_INC;
  assign nm_exp        = exp8 - fhc_pkg::REBIAS + {7'b0, nm_sum[23]};
  assign nan_man       = man[22:13];

  always_comb begin
    half_o = {sign, 15'b0};
    if (exp8 <= fhc_pkg::REBIAS) begin
      if (dn_shift < fhc_pkg::DENORM_SH_MAX) begin
        half_o = {sign, 4'b0, dn_round[23:13]};
      end
    end else if (exp8 == fhc_pkg::SINGLE_EXP_MAX) begin
      half_o = {sign, fhc_pkg::HALF_EXP_MAX, 10'b0};
      if (man != 23'b0) begin
        half_o[9:0] = (nan_man == 10'b0) ? 10'd1 : nan_man;
      end
    end else if (nm_exp >= fhc_pkg::HALF_EXP_OVF) begin
      half_o = {sign, fhc_pkg::HALF_EXP_MAX, 10'b0};
    end else begin
      half_o = {sign, nm_exp[4:0], nm_sum[23] ? 10'b0 : nm_sum[22:13]};
    end
  end

endmodule

FILE: rtl/fhc_widen.sv
// Combinational widening of a half-precision pattern to single precision.
// Depends on fhc_pkg.
module fhc_widen (
  input  fhc_pkg::half_t   half_i,
  output fhc_pkg::single_t single_o
);

  logic        sign;
  logic [4:0]  exp5;
  logic [9:0]  man;
  logic [3:0]  lz_shift;
  logic [10:0] norm;
  logic [7:0]  dn_exp;

  assign sign   = half_i[15];
  assign exp5   = half_i[14:10];
  assign man    = half_i[9:0];
  assign norm   = {1'b0, man} << lz_shift;
  assign dn_exp = fhc_pkg::DENORM_BASE - {4'b0, lz_shift};

  // Shift that brings the leading one to the implicit position.
  always_comb begin
    lz_shift = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) begin
        lz_shift = 4'(10 - i);
      end
    end
  end

  always_comb begin
    if (exp5 == 5'b0) begin
      if (man == 10'b0) begin
        single_o = {sign, 31'b0};
      end else begin
        single_o = {sign, dn_exp, norm[9:0], 13'b0};
      end
    end else if (exp5 == fhc_pkg::HALF_EXP_MAX) begin
      single_o = {sign, fhc_pkg::SINGLE_EXP_MAX, man, 13'b0};
    end else begin
      single_o = {sign, {3'b0, exp5} + fhc_pkg::REBIAS, man, 13'b0};
    end
  end

endmodule

FILE: rtl/float_half_converter.sv
// Converts between single and half precision float bit patterns, one
// transfer per cycle while out_ready_i is held high. An accepted item passes
// through an input register and a result register with one level of
// conversion logic between them; its result is offered from the result
// register, and a stalled result register holds the next item in the input
// register. out_ready_i reaches in_ready_o combinationally through both stages.
// Depends on fhc_pkg, fhc_narrow and fhc_widen.
module float_half_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] converted_o
);

  logic                 in_valid_q;
  fhc_pkg::cmd_e        cmd_q;
  fhc_pkg::single_t     value_q;
  logic                 out_valid_q;
  fhc_pkg::single_t     converted_q;
  fhc_pkg::single_t     converted_d;
  fhc_pkg::half_t       narrow_h;
  fhc_pkg::single_t     widen_s;
  logic                 res_ready;

  fhc_narrow u_fhc_narrow (
    .single_i (value_q),
    .half_o   (narrow_h)
  );

  fhc_widen u_fhc_widen (
    .half_i   (value_q[15:0]),
    .single_o (widen_s)
  );

  assign res_ready   = !out_valid_q || out_ready_i;
  assign in_ready_o  = !in_valid_q || res_ready;
  assign converted_d = (cmd_q == fhc_pkg::CMD_WIDEN) ? widen_s : {16'b0, narrow_h};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (res_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= fhc_pkg::cmd_e'(cmd_i);
      value_q <= value_i;
    end
    if (in_valid_q && res_ready) begin
      converted_q <= converted_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign converted_o = converted_q;

endmodule

FILE: rtl/fhc_checker.sv
// Port-level checks of the converter, bound to the top level.
// Depends on fhc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fhc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        cmd_i,
  input logic [31:0] value_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] converted_o
);

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_o && (value_i == value_i);

  `ASSERT_PROP(a_out_valid_hold, out_valid_o && !out_ready_i |=> out_valid_o, "out_valid dropped")
  `ASSERT_PROP(a_out_data_hold, out_valid_o && !out_ready_i |=> $stable(converted_o), "payload changed")
  `ASSERT_NEVER(a_ready_flow, out_ready_i && !in_ready_o, "input stalled while output drains")
  `ASSERT_PROP(a_narrow_upper, (in_xfer && cmd_i == fhc_pkg::CMD_NARROW) ##1 out_ready_i |=> out_valid_o && converted_o[31:16] == 16'b0, "narrow result lost or upper bits set")

endmodule

bind float_half_converter fhc_checker u_fhc_checker (.*);

FILE: bench/tb.sv
// Self-checking testbench for float_half_converter: random and directed
// single/half conversions through valid/ready, checked against a predictor.
// Depends on fhc_pkg and the float_half_converter RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 650;

  localparam int HALF_REBIAS = 112;
  localparam int NARROW_NAN_EXP = 143;
  localparam int HALF_OVF_EXP = 31;
  localparam logic [15:0] HALF_INF = 16'h7C00;

  typedef struct packed {
    fhc_pkg::cmd_e cmd;
    logic [31:0] value;
  } conv_req_t;

  typedef struct packed {
    conv_req_t req;
    logic [31:0] converted;
  } conv_exp_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic [31:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] converted;

  conv_req_t pending_q[$];
  conv_exp_t expected_q[$];
  bit failed = 1'b0;
  int unsigned cycle_cnt = 0;

  float_half_converter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .cmd_i      (cmd),
    .value_i    (value),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .converted_o(converted)
  );

  function automatic logic [31:0] narrow_to_half(logic [31:0] x);
    logic [15:0] h;
    logic [9:0] payload;
    logic [23:0] mant;
    logic [31:0] shifted;
    int ex;
    int sh;
    h = {x[31], 15'd0};
    ex = int'(x[30:23]) - HALF_REBIAS;
    mant = {1'b0, x[22:0]};
    if (ex <= 0) begin
      sh = 1 - ex;
      shifted = (sh >= 24) ? 32'd0 : ({8'd0, 1'b1, x[22:0]} >> sh);
      shifted = shifted + 32'h1000;
      h = h | shifted[28:13];
    end else if (ex == NARROW_NAN_EXP) begin
      h = h | HALF_INF;
      if (x[22:0] != 23'd0) begin
        payload = x[22:13];
        h = h | {6'd0, payload} | ((payload == 10'd0) ? 16'd1 : 16'd0);
      end
    end else begin
      mant = mant + 24'h001000;
      if (mant[23]) begin
        mant = '0;
        ex = ex + 1;
      end
      if (ex >= HALF_OVF_EXP) begin
        h = h | HALF_INF;
      end else begin
        h = h | {1'b0, ex[4:0], mant[22:13]};
      end
    end
    return {16'd0, h};
  endfunction

  function automatic logic [31:0] widen_to_single(logic [15:0] h);
    logic [10:0] mant;
    logic [7:0] ex8;
    int k;
    mant = {1'b0, h[9:0]};
    k = 0;
    if (h[14:10] == 5'd0) begin
      if (h[9:0] == 10'd0) begin
        return {h[15], 31'd0};
      end
      while (!mant[10] && k < 11) begin
        mant = mant << 1;
        k++;
      end
      ex8 = 8'(HALF_REBIAS + 1 - k);
      return {h[15], ex8, mant[9:0], 13'd0};
    end
    if (h[14:10] == 5'h1F) begin
      return {h[15], 8'hFF, h[9:0], 13'd0};
    end
    ex8 = 8'(int'(h[14:10]) + HALF_REBIAS);
    return {h[15], ex8, h[9:0], 13'd0};
  endfunction

  function automatic logic [31:0] predict_conversion(conv_req_t r);
    if (r.cmd == fhc_pkg::CMD_WIDEN) begin
      return widen_to_single(r.value[15:0]);
    end
    return narrow_to_half(r.value);
  endfunction

  task automatic queue_item(fhc_pkg::cmd_e c, logic [31:0] v);
    conv_req_t r;
    r.cmd = c;
    r.value = v;
    pending_q.push_back(r);
  endtask

  function automatic logic [31:0] random_single();
    logic [31:0] v;
    int unsigned pick;
    v = $urandom();
    pick = $urandom_range(0, 9);
    if (pick >= 3 && pick <= 8) begin
      v[30:23] = 8'($urandom_range(86, 145));
      case ($urandom_range(0, 3))
        0: v[12:0] = 13'h1000;
        1: v[12:0] = 13'h0FFF;
        2: v[22:13] = 10'h3FF;
        default: ;
      endcase
    end else if (pick == 9) begin
      v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 2) == 0) begin
        v[22:0] = '0;
      end else if ($urandom_range(0, 1) == 0) begin
        v[22:13] = '0;
      end
    end
    return v;
  endfunction

  function automatic logic [31:0] random_half();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 5))
      0: v[14:10] = 5'h00;
      1: v[14:10] = 5'h1F;
      2: v[9:0] = '0;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("FAIL float_half_converter");
      $finish;
    end
  end

  // Driver: bursts of transfers separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    conv_req_t r;
    conv_exp_t e;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      cmd <= 1'b0;
      value <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        e.req.cmd = fhc_pkg::cmd_e'(cmd);
        e.req.value = value;
        e.converted = predict_conversion(e.req);
        expected_q.push_back(e);
      end
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        r = pending_q.pop_front();
        in_valid <= 1'b1;
        cmd <= r.cmd;
        value <= r.value;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches between modes, including open stretches.
  rx_mode_e rx_mode = RX_OPEN;
  int unsigned rx_phase_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_phase_left = $urandom_range(20, 120);
      end else begin
        rx_phase_left--;
      end
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= cycle_cnt[2];
      endcase
    end
  end

  // Monitor: compare each transfer with the oldest prediction.
  always @(posedge clk_i) begin
    conv_exp_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("converted: unexpected result %h", converted);
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        if (converted !== e.converted) begin
          $error("converted mismatch (cmd %0d value %h): expected %h actual %h",
                 e.req.cmd, e.req.value, e.converted, converted);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    queue_item(fhc_pkg::CMD_NARROW, 32'h0000_0000);
    queue_item(fhc_pkg::CMD_NARROW, 32'h8000_0000);
    queue_item(fhc_pkg::CMD_NARROW, 32'h0000_0001);
    queue_item(fhc_pkg::CMD_NARROW, 32'h7F80_0000);
    queue_item(fhc_pkg::CMD_NARROW, 32'hFF80_0000);
    queue_item(fhc_pkg::CMD_NARROW, 32'h7F80_0001);
    queue_item(fhc_pkg::CMD_NARROW, 32'hFFC0_0000);
    queue_item(fhc_pkg::CMD_NARROW, 32'hFFFF_FFFF);
    queue_item(fhc_pkg::CMD_NARROW, 32'h477F_E000);
    queue_item(fhc_pkg::CMD_NARROW, 32'h477F_F000);
    queue_item(fhc_pkg::CMD_NARROW, 32'hC780_0000);
    queue_item(fhc_pkg::CMD_NARROW, 32'h387F_F000);
    queue_item(fhc_pkg::CMD_NARROW, 32'h3F80_1000);
    queue_item(fhc_pkg::CMD_NARROW, 32'h2CFF_FFFF);
    queue_item(fhc_pkg::CMD_NARROW, 32'hAD00_0000);
    queue_item(fhc_pkg::CMD_NARROW, 32'h3380_0000);
    queue_item(fhc_pkg::CMD_WIDEN, 32'h0000_0000);
    queue_item(fhc_pkg::CMD_WIDEN, 32'h0000_8000);
    queue_item(fhc_pkg::CMD_WIDEN, 32'h0000_0001);
    queue_item(fhc_pkg::CMD_WIDEN, 32'h0000_83FF);
    queue_item(fhc_pkg::CMD_WIDEN, 32'h0000_7BFF);
    queue_item(fhc_pkg::CMD_WIDEN, 32'h0000_FC00);
    queue_item(fhc_pkg::CMD_WIDEN, 32'h0000_7C01);
    queue_item(fhc_pkg::CMD_WIDEN, 32'hFFFF_0400);
    queue_item(fhc_pkg::CMD_WIDEN, 32'hFFFF_FFFF);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        queue_item(fhc_pkg::CMD_NARROW, random_single());
      end else begin
        queue_item(fhc_pkg::CMD_WIDEN, random_half());
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (!failed) begin
      $display("PASS float_half_converter");
    end else begin
      $display("FAIL float_half_converter");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/fhc_pkg.sv
rtl/fhc_narrow.sv
rtl/fhc_widen.sv
rtl/float_half_converter.sv
rtl/fhc_checker.sv
bench/tb.sv
